// ===== rtl/etnm_pkg.sv =====
// Package of shared constants and types for the event timeline block.
package etnm_pkg;
  localparam int unsigned Depth = 256;
  localparam int unsigned TimeBits = 48;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AddrBits = $clog2(Depth);
  localparam int unsigned CntBits = AddrBits + 1;
  localparam int unsigned RatioBits = FracBits + 1;
  localparam int unsigned KeyBits = 8;
  localparam int unsigned EntryBits = TimeBits + KeyBits;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic opcode;
    logic [KeyBits-1:0] in_key;
    logic [TimeBits-1:0] in_time;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [KeyBits-1:0] closest_key;
    logic [TimeBits-1:0] closest_offset;
    logic [RatioBits-1:0] progress_ratio;
    logic [CntBits-1:0] stored_count;
  } rsp_t;
endpackage

// ===== rtl/etnm_if.sv =====
// Valid/ready channel interfaces carrying request and response transactions.
interface etnm_req_if import etnm_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface etnm_rsp_if import etnm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/etnm_ram.sv =====
// Generic single-port RAM with registered read.
module etnm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/event_timeline_nearest_match.sv =====
// Top level of the event timeline with nearest-match and progress queries.
//
// The block holds up to 256 events (8-bit key, 48-bit timestamp) in a RAM,
// sorted by time. Transactions arrive on req (opcode, in_key, in_time) and
// each produces exactly one response transaction on rsp.
//
// An insert walks downwards from the end of the table, moving each later
// entry up one place, each move being a read and then a write. A full
// table drops the insert.
// A query scans all stored entries, tracking the nearest event (earliest
// wins a tie) and the bracketing pair. A restoring divider then produces
// the Q1.16 ratio one bit per cycle.
//
// One transaction is worked on at a time; req ready is high only when the
// sequencer is idle. The response is held in an output register until it
// is taken, and the sequencer stays idle-blocked while rsp is stalled.
// Reset clears the state, the entry count and the response valid flag; the
// RAM contents are never read beyond the count, so no clearing pass is needed.
module event_timeline_nearest_match
  import etnm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  etnm_req_if.sink   req,
  etnm_rsp_if.source rsp
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StInsRd  = 10'b0000000010,
    StInsChk = 10'b0000000100,
    StInsWr  = 10'b0000001000,
    StQRd    = 10'b0000010000,
    StQChk   = 10'b0000100000,
    StQRatio = 10'b0001000000,
    StDiv    = 10'b0010000000,
    StDone   = 10'b0100000000,
    StOut    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [CntBits-1:0] count_q;
  logic [CntBits-1:0] idx_q;      // walk index
  req_t               req_q;

  logic                 ram_we;
  logic [AddrBits-1:0]  ram_addr;
  logic [EntryBits-1:0] ram_wdata, ram_rdata;
  logic [TimeBits-1:0]  rd_time;
  logic [KeyBits-1:0]   rd_key;

  // Query tracking registers.
  logic [TimeBits-1:0] best_q;
  logic [KeyBits-1:0]  bkey_q;
  logic [TimeBits-1:0] first_q, ta_q, tb_q;
  logic                have_b_q;  // t_b captured for current t_a

  // Divider registers.
  logic [TimeBits:0]    rem_q;
  logic [TimeBits-1:0]  den_q;
  logic [RatioBits-1:0] quo_q;
  logic [4:0]           bit_q;

  rsp_t rsp_q;
  logic rsp_valid_q;

  assign rd_time = ram_rdata[EntryBits-1:KeyBits];
  assign rd_key  = ram_rdata[KeyBits-1:0];

  etnm_ram #(.Width(EntryBits), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign req.ready   = (state_q == StIdle) && !rsp_valid_q;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  logic [TimeBits-1:0] diff;
  logic [TimeBits:0]   rem_sh;
  logic                idx_last;
  assign diff = (rd_time >= req_q.in_time) ? rd_time - req_q.in_time
                                           : req_q.in_time - rd_time;
  assign rem_sh = {rem_q[TimeBits-1:0], 1'b0};
  assign idx_last = (idx_q == count_q - CntBits'(1));

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_q[AddrBits-1:0];
    ram_wdata = ram_rdata;
    case (state_q)
      StInsRd:  ram_addr = AddrBits'(idx_q - CntBits'(1));
      StInsChk: begin
        // Shift the entry below up into slot idx.
        if (rd_time > req_q.in_time) begin
          ram_we = 1'b1;
        end
      end
      StInsWr: begin
        ram_we    = 1'b1;
        ram_wdata = {req_q.in_time, req_q.in_key};
      end
      default: ram_addr = idx_q[AddrBits-1:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (req.valid && req.ready) begin
        if (req.payload.opcode == OpInsert) begin
          state_d = StDone;
          if (count_q != CntBits'(Depth)) begin
            state_d = (count_q == '0) ? StInsWr : StInsRd;
          end
        end else begin
          state_d = (count_q == '0) ? StDone : StQRd;
        end
      end
      StInsRd:  state_d = StInsChk;
      StInsChk: state_d = (rd_time > req_q.in_time && idx_q != CntBits'(1)) ? StInsRd
                                                                            : StInsWr;
      StInsWr:  state_d = StDone;
      StQRd:    state_d = StQChk;
      StQChk:   state_d = idx_last ? StQRatio : StQRd;
      StQRatio: state_d = StDiv;
      StDiv:    if (bit_q == 5'(FracBits)) state_d = StDone;
      StDone:   state_d = StOut;
      StOut:    state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (state_q == StInsWr) begin
        count_q <= count_q + CntBits'(1);
      end
      if (state_q == StOut) begin
        rsp_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: if (req.valid && req.ready) begin
        req_q    <= req.payload;
        idx_q    <= (req.payload.opcode == OpInsert) ? count_q : '0;
        have_b_q <= 1'b0;
        quo_q    <= '0;
        rsp_q.status         <= StatusOk;
        rsp_q.closest_key    <= '0;
        rsp_q.closest_offset <= '0;
        if (req.payload.opcode == OpInsert && count_q == CntBits'(Depth)) begin
          rsp_q.status <= StatusFull;
        end
        if (req.payload.opcode == OpQuery && count_q == '0) begin
          rsp_q.status         <= StatusEmpty;
          rsp_q.closest_offset <= '1;
        end
      end
      StInsChk: if (rd_time > req_q.in_time) begin
        idx_q <= idx_q - CntBits'(1);
      end
      StQChk: begin
        if (idx_q == '0 || diff < best_q) begin
          best_q <= diff;
          bkey_q <= rd_key;
        end
        if (idx_q == '0) first_q <= rd_time;
        if (rd_time <= req_q.in_time) begin
          ta_q     <= rd_time;
          have_b_q <= 1'b0;
        end else if (!have_b_q) begin
          tb_q     <= rd_time;
          have_b_q <= 1'b1;
        end
        idx_q <= idx_q + CntBits'(1);
      end
      StQRatio: begin
        rsp_q.closest_key    <= bkey_q;
        rsp_q.closest_offset <= best_q;
        bit_q <= '0;
        if (req_q.in_time <= first_q) begin
          if (first_q == '0) begin
            quo_q <= RatioBits'(1) << FracBits;
            bit_q <= 5'(FracBits);
            den_q <= '0;
          end else begin
            den_q <= first_q;
            rem_q <= {1'b0, req_q.in_time};
          end
        end else if (!have_b_q || tb_q == ta_q) begin
          quo_q <= RatioBits'(1) << FracBits;
          bit_q <= 5'(FracBits);
          den_q <= '0;
        end else begin
          den_q <= tb_q - ta_q;
          rem_q <= {1'b0, req_q.in_time - ta_q};
        end
      end
      StDiv: if (den_q != '0) begin
        if (bit_q == '0) begin
          if (rem_q >= {1'b0, den_q}) begin
            rem_q <= rem_q - {1'b0, den_q};
            quo_q <= RatioBits'(1);
          end
          bit_q <= bit_q + 5'd1;
        end else begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[RatioBits-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[RatioBits-2:0], 1'b0};
          end
          if (bit_q != 5'(FracBits)) bit_q <= bit_q + 5'd1;
        end
      end
      StDone: begin
        rsp_q.stored_count   <= count_q;
        rsp_q.progress_ratio <= (req_q.opcode == OpQuery && rsp_q.status == StatusOk)
                                ? quo_q : '0;
      end
      default: ;
    endcase
  end

endmodule
